### src/kopp_pkg.sv
// ----------------------------------------------------------------------------
// kopp_pkg
// Shared types and constants of the key origin path parser: request and
// response payloads, parser state, phase and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kopp_pkg;

   localparam int MAX_STEPS = 16;
   localparam int STEPS_W   = $clog2(MAX_STEPS + 1);

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [3:0] FP_CHARS = 4'd8;

   typedef enum logic [1:0] {
      PH_FP    = 2'd0,
      PH_PATH  = 2'd1,
      PH_DRAIN = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BAD_LEN  = 3'd2,
      ST_BAD_KEY  = 3'd3,
      ST_RANGE    = 3'd4,
      ST_TOO_MANY = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] character;
      logic       char_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        step_valid;
      logic [3:0]  step_index;
      logic [31:0] step_value;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] fingerprint;
      logic [4:0]  step_count;
   } rsp_type;

   typedef struct packed {
      phase_type          phase;
      logic [3:0]         chars_seen;
      logic [31:0]        fp_accum;
      logic               hex_bad;
      logic [30:0]        token_accum;
      logic [1:0]         token_len;
      logic               token_first_zero;
      logic               apostrophe_pending;
      logic               token_bad;
      logic [STEPS_W-1:0] steps_done;
      status_type         error_code;
   } state_type;

   localparam state_type STATE_RST = '{
      phase:              PH_FP,
      chars_seen:         4'd0,
      fp_accum:           32'd0,
      hex_bad:            1'b0,
      token_accum:        31'd0,
      token_len:          2'd0,
      token_first_zero:   1'b0,
      apostrophe_pending: 1'b0,
      token_bad:          1'b0,
      steps_done:         '0,
      error_code:         ST_OK
   };

endpackage

`default_nettype wire

### src/kopp_step.sv
// ----------------------------------------------------------------------------
// kopp_step
// Next-state and response logic for one request: fingerprint hex capture,
// decimal step accumulation, step close checks and end-of-text result.
// ----------------------------------------------------------------------------
`default_nettype none

module kopp_step (
   input  kopp_pkg::state_type cur_state,
   input  kopp_pkg::req_type   req,
   output kopp_pkg::state_type nxt_state,
   output kopp_pkg::rsp_type   rsp,
   output logic                rsp_emit
);

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] h;
      h = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         h = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h = 5'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h = 5'(c - 8'h41 + 8'd10);
      end
      return h;
   endfunction

   function automatic kopp_pkg::state_type do_fail(input kopp_pkg::state_type s,
                                                   input kopp_pkg::status_type code);
      kopp_pkg::state_type r;
      r = s;
      if (r.error_code == kopp_pkg::ST_OK) begin
         r.error_code = code;
      end
      r.phase = kopp_pkg::PH_DRAIN;
      return r;
   endfunction

   function automatic kopp_pkg::state_type token_clear(input kopp_pkg::state_type s);
      kopp_pkg::state_type r;
      r = s;
      r.token_accum        = '0;
      r.token_len          = '0;
      r.token_first_zero   = 1'b0;
      r.apostrophe_pending = 1'b0;
      r.token_bad          = 1'b0;
      return r;
   endfunction

   function automatic kopp_pkg::state_type token_add(input kopp_pkg::state_type s,
                                                     input logic [7:0] c);
      kopp_pkg::state_type r;
      logic [34:0]         v;
      logic                digit;
      r = s;
      // an apostrophe that was not final counts as a bad character
      if (r.apostrophe_pending) begin
         r.token_bad = 1'b1;
         if (r.token_len == 2'd0) begin
            r.token_first_zero = 1'b0;
         end
         if (r.token_len < 2'd2) begin
            r.token_len = r.token_len + 2'd1;
         end
         r.apostrophe_pending = 1'b0;
      end
      if (c == kopp_pkg::CH_APOS) begin
         r.apostrophe_pending = 1'b1;
      end else begin
         if (r.token_len == 2'd0) begin
            r.token_first_zero = (c == kopp_pkg::CH_ZERO);
         end
         if (r.token_len < 2'd2) begin
            r.token_len = r.token_len + 2'd1;
         end
         if (!r.token_bad) begin
            digit = (c >= 8'h30 && c <= 8'h39);
            // times ten as shift and add
            v = {1'b0, r.token_accum, 3'b000} + {3'b000, r.token_accum, 1'b0}
                + {31'd0, c[3:0]};
            if (!digit || v[34:31] != 4'd0) begin
               r.token_bad = 1'b1;
            end else begin
               r.token_accum = v[30:0];
            end
         end
      end
      return r;
   endfunction

   function automatic kopp_pkg::status_type close_check(input kopp_pkg::state_type s);
      kopp_pkg::status_type code;
      code = kopp_pkg::ST_OK;
      if (s.token_len == 2'd0) begin
         code = kopp_pkg::ST_BAD_KEY;
      end else if (s.token_first_zero && s.token_len >= 2'd2) begin
         code = kopp_pkg::ST_RANGE;
      end else if (s.token_bad) begin
         code = kopp_pkg::ST_BAD_KEY;
      end else if (s.steps_done >= kopp_pkg::STEPS_W'(kopp_pkg::MAX_STEPS)) begin
         code = kopp_pkg::ST_TOO_MANY;
      end
      return code;
   endfunction

   kopp_pkg::state_type               s;
   kopp_pkg::status_type              code;
   logic [4:0]                        h;
   logic [kopp_pkg::STEPS_W+4:0]      steps_ext;

   always_comb begin
      s         = cur_state;
      rsp       = '0;
      rsp_emit  = 1'b0;
      code      = kopp_pkg::ST_OK;
      h         = hex_digit(req.character);
      steps_ext = '0;

      if (req.char_present) begin
         case (s.phase)
            kopp_pkg::PH_FP: begin
               if (req.character == kopp_pkg::CH_SLASH) begin
                  if (s.chars_seen != kopp_pkg::FP_CHARS) begin
                     s = do_fail(s, kopp_pkg::ST_BAD_LEN);
                  end else if (s.hex_bad) begin
                     s = do_fail(s, kopp_pkg::ST_BAD_KEY);
                  end else begin
                     s.phase = kopp_pkg::PH_PATH;
                     s = token_clear(s);
                  end
               end else begin
                  if (s.chars_seen < kopp_pkg::FP_CHARS) begin
                     if (h[4]) begin
                        s.hex_bad = 1'b1;
                     end else begin
                        s.fp_accum = {s.fp_accum[27:0], h[3:0]};
                     end
                  end
                  if (s.chars_seen < 4'd9) begin
                     s.chars_seen = s.chars_seen + 4'd1;
                  end
               end
            end
            kopp_pkg::PH_PATH: begin
               if (req.character == kopp_pkg::CH_SLASH) begin
                  code = close_check(s);
                  if (code == kopp_pkg::ST_OK) begin
                     steps_ext      = {5'd0, s.steps_done};
                     rsp.step_valid = 1'b1;
                     rsp.step_index = steps_ext[3:0];
                     rsp.step_value = {s.apostrophe_pending, s.token_accum};
                     rsp_emit       = 1'b1;
                     s.steps_done   = s.steps_done + kopp_pkg::STEPS_W'(1);
                     s = token_clear(s);
                  end else begin
                     s = do_fail(s, code);
                  end
               end else begin
                  s = token_add(s, req.character);
               end
            end
            default: begin
            end
         endcase
      end

      if (req.last) begin
         case (s.phase)
            kopp_pkg::PH_FP: begin
               if (s.chars_seen == 4'd0) begin
                  s = do_fail(s, kopp_pkg::ST_EMPTY);
               end else if (s.chars_seen != kopp_pkg::FP_CHARS) begin
                  s = do_fail(s, kopp_pkg::ST_BAD_LEN);
               end else if (s.hex_bad) begin
                  s = do_fail(s, kopp_pkg::ST_BAD_KEY);
               end
            end
            kopp_pkg::PH_PATH: begin
               if (close_check(s) == kopp_pkg::ST_OK) begin
                  steps_ext      = {5'd0, s.steps_done};
                  rsp.step_valid = 1'b1;
                  rsp.step_index = steps_ext[3:0];
                  rsp.step_value = {s.apostrophe_pending, s.token_accum};
                  s.steps_done   = s.steps_done + kopp_pkg::STEPS_W'(1);
               end else begin
                  s = do_fail(s, close_check(s));
               end
            end
            default: begin
            end
         endcase
         steps_ext    = {5'd0, s.steps_done};
         rsp.done_res = 1'b1;
         rsp.status   = s.error_code;
         if (s.error_code == kopp_pkg::ST_OK) begin
            rsp.fingerprint = s.fp_accum;
            rsp.step_count  = steps_ext[4:0];
         end else begin
            rsp.step_valid = 1'b0;
            rsp.step_index = '0;
            rsp.step_value = '0;
         end
         rsp_emit = 1'b1;
         s = kopp_pkg::STATE_RST;
      end

      nxt_state = s;
   end

endmodule

`default_nettype wire

### src/key_origin_path_parser.sv
// ----------------------------------------------------------------------------
// key_origin_path_parser
// Streams a key origin text one character per request: an 8 hex digit
// fingerprint followed by '/'-separated decimal steps, hardened with a
// trailing apostrophe.
//
// req channel: valid/ready, one character (or an end-only marker) per
// request; last closes the text. rsp channel: valid/ready, at most one
// response per request, either a completed step, the final result with
// status, fingerprint and step count, or both when the end closes a step.
// A request with no character and no last is consumed silently.
//
// A request is captured in the request register when it is accepted, and
// the parser logic then loads the response register from it once that
// register is empty or being read. Throughput is one request per cycle
// while no held response stalls it. When rsp_ready is low the response
// register holds and one further request waits in the request register
// before req_ready drops. Synchronous reset empties both registers and
// returns the parser to the start of a text.
// ----------------------------------------------------------------------------
`default_nettype none

module key_origin_path_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire kopp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output kopp_pkg::rsp_type      rsp_data
);

   kopp_pkg::req_type   req_ff;
   logic                req_valid_ff;
   kopp_pkg::state_type state_ff;
   kopp_pkg::state_type state_in;
   kopp_pkg::rsp_type   rsp_ff;
   kopp_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                emit;
   logic                advance;

   kopp_step u_step (
      .cur_state (state_ff),
      .req       (req_ff),
      .nxt_state (state_in),
      .rsp       (rsp_in),
      .rsp_emit  (emit)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= kopp_pkg::STATE_RST;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### dv/key_origin_path_parser_tb.sv
// ----------------------------------------------------------------------------
// key_origin_path_parser_tb
// Self-checking bench for the key origin path parser. A short table of
// hand-picked requests comes first, with the final response written out where
// it is obvious. Random origin texts follow: mostly well formed fingerprints
// and paths with random steps, plus noise. A behavioral model of the parser
// predicts every response, and each accepted response is checked field by
// field in order. Both sides idle in random bursts, the receiver twice holds
// off long enough to stall the request side, and the sender once waits for
// the pipe to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module key_origin_path_parser_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS      = 500;
   localparam int IDLE_LIMIT = 400;
   localparam int LONG_HOLD  = 60;

   typedef struct packed {
      kopp_pkg::req_type rq;
      logic              typed;
      kopp_pkg::rsp_type rs;
   } dir_row_type;

   localparam kopp_pkg::rsp_type NO_RSP = '0;
   localparam kopp_pkg::rsp_type DONE_EMPTY = '{step_valid: 1'b0, step_index: 4'd0,
      step_value: 32'd0, done_res: 1'b1, status: kopp_pkg::ST_EMPTY, fingerprint: 32'd0,
      step_count: 5'd0};
   localparam kopp_pkg::rsp_type DONE_BAD_LEN = '{step_valid: 1'b0, step_index: 4'd0,
      step_value: 32'd0, done_res: 1'b1, status: kopp_pkg::ST_BAD_LEN, fingerprint: 32'd0,
      step_count: 5'd0};
   localparam kopp_pkg::rsp_type DONE_BAD_KEY = '{step_valid: 1'b0, step_index: 4'd0,
      step_value: 32'd0, done_res: 1'b1, status: kopp_pkg::ST_BAD_KEY, fingerprint: 32'd0,
      step_count: 5'd0};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kopp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kopp_pkg::rsp_type rsp_data;

   // directed requests: idle, empty text, length errors, then a text whose
   // first step is hardened zero and whose second step is empty
   dir_row_type dir_tab [19] = '{
      '{'{8'h5a, 1'b0, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, DONE_EMPTY},
      '{'{8'h00, 1'b1, 1'b1}, 1'b1, DONE_BAD_LEN},
      '{'{8'hff, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_SLASH, 1'b1, 1'b1}, 1'b1, DONE_BAD_LEN},
      '{'{8'h30, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h46, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h39, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h66, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h41, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h39, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'h63, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_SLASH, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_ZERO, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_APOS, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_SLASH, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{kopp_pkg::CH_SLASH, 1'b1, 1'b0}, 1'b0, NO_RSP},
      '{'{8'hff, 1'b0, 1'b1}, 1'b1, DONE_BAD_KEY}
   };

   // parser model state
   kopp_pkg::phase_type  ph;
   logic [3:0]           seen_cnt;
   logic [31:0]          fp_acc;
   logic                 hex_err;
   logic [31:0]          tok_acc;
   logic [1:0]           tok_len;
   logic                 tok_zero;
   logic                 tok_apos;
   logic                 tok_err;
   int                   step_cnt;
   kopp_pkg::status_type err_code;

   kopp_pkg::rsp_type rsp_expect_q [$];
   kopp_pkg::req_type text_q [$];
   kopp_pkg::req_type next_req;
   kopp_pkg::rsp_type want_rsp;

   int   mismatches = 0;
   int   req_total = 0;
   int   texts_sent = 0;
   int   steps_seen = 0;
   int   finals_seen = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic rx_ready_next;
   logic quiet = 1'b0;
   logic long_hold_req = 1'b0;
   logic drained = 1'b0;

   key_origin_path_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic clear_token();
      tok_acc  = '0;
      tok_len  = '0;
      tok_zero = 1'b0;
      tok_apos = 1'b0;
      tok_err  = 1'b0;
   endtask

   task automatic reset_parser();
      ph       = kopp_pkg::PH_FP;
      seen_cnt = '0;
      fp_acc   = '0;
      hex_err  = 1'b0;
      step_cnt = 0;
      err_code = kopp_pkg::ST_OK;
      clear_token();
   endtask

   task automatic flag_error(input kopp_pkg::status_type code);
      if (err_code == kopp_pkg::ST_OK) err_code = code;
      ph = kopp_pkg::PH_DRAIN;
   endtask

   task automatic close_token(output logic ok, inout kopp_pkg::rsp_type o);
      ok = 1'b0;
      if (tok_len == 0) flag_error(kopp_pkg::ST_BAD_KEY);
      else if (tok_zero && tok_len >= 2) flag_error(kopp_pkg::ST_RANGE);
      else if (tok_err) flag_error(kopp_pkg::ST_BAD_KEY);
      else if (step_cnt >= kopp_pkg::MAX_STEPS) flag_error(kopp_pkg::ST_TOO_MANY);
      else begin
         o.step_valid = 1'b1;
         o.step_index = step_cnt[3:0];
         o.step_value = {tok_apos, tok_acc[30:0]};
         step_cnt++;
         ok = 1'b1;
      end
   endtask

   task automatic predict_rsp(input kopp_pkg::req_type r, output logic emit,
                              output kopp_pkg::rsp_type o);
      logic [7:0] c;
      logic [3:0] nib;
      logic       is_hex;
      logic       closed;
      longint     acc;
      begin
         c    = r.character;
         emit = 1'b0;
         o    = '0;
         if (r.char_present) begin
            case (ph)
               kopp_pkg::PH_FP: begin
                  if (c == kopp_pkg::CH_SLASH) begin
                     if (seen_cnt != kopp_pkg::FP_CHARS) flag_error(kopp_pkg::ST_BAD_LEN);
                     else if (hex_err) flag_error(kopp_pkg::ST_BAD_KEY);
                     else begin
                        ph = kopp_pkg::PH_PATH;
                        clear_token();
                     end
                  end else begin
                     if (seen_cnt < kopp_pkg::FP_CHARS) begin
                        is_hex = 1'b1;
                        nib    = '0;
                        if (c >= kopp_pkg::CH_ZERO && c <= 8'h39)
                           nib = 4'(c - kopp_pkg::CH_ZERO);
                        else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
                        else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
                        else is_hex = 1'b0;
                        if (is_hex) fp_acc = {fp_acc[27:0], nib};
                        else hex_err = 1'b1;
                     end
                     if (seen_cnt < 9) seen_cnt++;
                  end
               end
               kopp_pkg::PH_PATH: begin
                  if (c == kopp_pkg::CH_SLASH) begin
                     close_token(closed, o);
                     if (closed) emit = 1'b1;
                     if (ph == kopp_pkg::PH_PATH) clear_token();
                  end else begin
                     // an apostrophe followed by more text is a bad character
                     if (tok_apos) begin
                        tok_err = 1'b1;
                        if (tok_len == 0) tok_zero = 1'b0;
                        if (tok_len < 2) tok_len++;
                        tok_apos = 1'b0;
                     end
                     if (c == kopp_pkg::CH_APOS) tok_apos = 1'b1;
                     else begin
                        if (tok_len == 0) tok_zero = (c == kopp_pkg::CH_ZERO);
                        if (tok_len < 2) tok_len++;
                        if (!tok_err) begin
                           if (c >= kopp_pkg::CH_ZERO && c <= 8'h39) begin
                              acc = longint'(tok_acc) * 10 + longint'(c) - 48;
                              if (acc >= 64'h8000_0000) tok_err = 1'b1;
                              else tok_acc = acc[31:0];
                           end else begin
                              tok_err = 1'b1;
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         if (r.last) begin
            if (ph == kopp_pkg::PH_FP) begin
               if (seen_cnt == 0) flag_error(kopp_pkg::ST_EMPTY);
               else if (seen_cnt != kopp_pkg::FP_CHARS) flag_error(kopp_pkg::ST_BAD_LEN);
               else if (hex_err) flag_error(kopp_pkg::ST_BAD_KEY);
            end else if (ph == kopp_pkg::PH_PATH) begin
               close_token(closed, o);
            end
            o.done_res = 1'b1;
            o.status   = err_code;
            if (err_code == kopp_pkg::ST_OK) begin
               o.fingerprint = fp_acc;
               o.step_count  = 5'(step_cnt);
            end else begin
               o.step_valid = 1'b0;
               o.step_index = '0;
               o.step_value = '0;
            end
            emit = 1'b1;
            reset_parser();
         end
      end
   endtask

   // offer one request from a falling edge, return at the falling edge after
   // it was taken
   task automatic send_req(input kopp_pkg::req_type r, input logic typed,
                           input kopp_pkg::rsp_type typed_rsp);
      logic              emit;
      kopp_pkg::rsp_type o;
      begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         req_data  <= r;
         req_valid <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         predict_rsp(r, emit, o);
         if (emit) rsp_expect_q.push_back(typed ? typed_rsp : o);
         @(negedge clock);
      end
   endtask

   function automatic logic [7:0] hex_char();
      int k;
      begin
         k = $urandom_range(0, 21);
         if (k < 10) return 8'(kopp_pkg::CH_ZERO + k);
         else if (k < 16) return 8'(8'h61 + k - 10);
         else return 8'(8'h41 + k - 16);
      end
   endfunction

   task automatic push_char(input logic [7:0] c);
      if ($urandom_range(0, 15) == 0)
         text_q.push_back(kopp_pkg::req_type'{character: 8'($urandom), char_present: 1'b0,
                                              last: 1'b0});
      text_q.push_back(kopp_pkg::req_type'{character: c, char_present: 1'b1, last: 1'b0});
   endtask

   task automatic push_number(input longint unsigned v);
      logic [7:0] digits [$];
      begin
         do begin
            digits.push_front(8'(kopp_pkg::CH_ZERO + v % 10));
            v = v / 10;
         end while (v != 0);
         foreach (digits[i]) push_char(digits[i]);
      end
   endtask

   task automatic build_text();
      int fp_len;
      int n_steps;
      int sel;
      int kind;
      begin
         text_q.delete();
         if ($urandom_range(0, 9) < 8) begin
            fp_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : 8;
            repeat (fp_len)
               push_char(($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255)) : hex_char());
            sel = $urandom_range(0, 19);
            n_steps = (sel < 16) ? $urandom_range(0, 4) :
                      (sel < 18) ? $urandom_range(5, 12) : $urandom_range(15, 18);
            repeat (n_steps) begin
               push_char(kopp_pkg::CH_SLASH);
               kind = $urandom_range(0, 19);
               case (kind)
                  0, 1, 2, 3, 4, 5, 6, 7, 8: push_number($urandom_range(0, 999));
                  9, 10: push_number(64'd2147483647 - $urandom_range(0, 3));
                  11: begin
                     if ($urandom_range(0, 1)) push_number(64'd2147483648 + $urandom_range(0, 9));
                     else push_number(64'd99999999999);
                  end
                  12: begin
                     push_char(kopp_pkg::CH_ZERO);
                     if ($urandom_range(0, 1)) push_number($urandom_range(0, 99));
                     else push_number(64'd4294967296);
                  end
                  13: ;
                  14: begin
                     push_number($urandom_range(0, 99));
                     push_char(8'($urandom_range(0, 255)));
                  end
                  15: begin
                     push_number($urandom_range(0, 99));
                     push_char(kopp_pkg::CH_APOS);
                     push_number($urandom_range(0, 9));
                  end
                  default: push_char(8'(kopp_pkg::CH_ZERO + $urandom_range(0, 9)));
               endcase
               if ($urandom_range(0, 1)) push_char(kopp_pkg::CH_APOS);
            end
         end else begin
            repeat ($urandom_range(0, 10)) begin
               sel = $urandom_range(0, 3);
               push_char((sel < 2) ? hex_char() :
                         (sel == 2) ?
                            (($urandom_range(0, 1)) ? kopp_pkg::CH_SLASH : kopp_pkg::CH_APOS) :
                         8'($urandom_range(0, 255)));
            end
         end
         if (text_q.size() == 0 || $urandom_range(0, 3) == 0)
            text_q.push_back(kopp_pkg::req_type'{character: 8'($urandom), char_present: 1'b0,
                                                 last: 1'b1});
         else
            text_q[$].last = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 200)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // response pacing: random stalls, one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rx_ready_next = 1'b0;
      end else if (quiet) begin
         rx_ready_next = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rx_ready_next = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left    = $urandom_range(1, 5) - 1;
         rx_ready_next = 1'b0;
      end else begin
         rx_ready_next = 1'b1;
      end
      rsp_ready <= rx_ready_next;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expect_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_data);
         end else begin
            want_rsp = rsp_expect_q.pop_front();
            check_field("step_valid", want_rsp.step_valid, rsp_data.step_valid);
            check_field("step_index", want_rsp.step_index, rsp_data.step_index);
            check_field("step_value", want_rsp.step_value, rsp_data.step_value);
            check_field("done_res", want_rsp.done_res, rsp_data.done_res);
            check_field("status", want_rsp.status, rsp_data.status);
            check_field("fingerprint", want_rsp.fingerprint, rsp_data.fingerprint);
            check_field("step_count", want_rsp.step_count, rsp_data.step_count);
         end
         if (rsp_data.step_valid) steps_seen++;
         if (rsp_data.done_res) finals_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, IDLE_LIMIT, rsp_expect_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset_parser();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);

      long_hold_req = 1'b1;
      while (req_total < ITEMS) begin
         build_text();
         while (text_q.size() != 0) begin
            next_req = text_q.pop_front();
            send_req(next_req, 1'b0, NO_RSP);
            if (next_req.char_present || next_req.last) req_total++;
         end
         texts_sent++;
         if (!drained && req_total >= ITEMS / 2) begin
            drained   = 1'b1;
            req_valid <= 1'b0;
            do @(negedge clock); while (rsp_expect_q.size() != 0);
            long_hold_req = 1'b1;
         end
         if (req_total >= ITEMS - 70) quiet = 1'b1;
      end
      req_valid <= 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (rsp_expect_q.size() != 0) begin
         mismatches++;
         $display("%0t: %0d responses never arrived", $time, rsp_expect_q.size());
      end

      $display("%0d random texts, %0d text requests after the table", texts_sent, req_total);
      $display("%0d step responses and %0d final responses checked", steps_seen, finals_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
src/kopp_pkg.sv
src/kopp_step.sv
src/key_origin_path_parser.sv
dv/key_origin_path_parser_tb.sv
